### rtl/call_duration_stats_table_macros.svh
// assertion macros for the call duration statistics table
// used by modules that assert; expects clk and arst_n in scope
`ifndef CALL_DURATION_STATS_TABLE_MACROS_SVH
`define CALL_DURATION_STATS_TABLE_MACROS_SVH

// checked only outside reset
`define CDST_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// checked at every edge, reset included
`define CDST_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

### rtl/cdst_pkg.sv
// shared types and constants of the call duration statistics table
// no dependencies
package cdst_pkg;

	localparam int TableSlotsDef = 64;
	localparam int TickW         = 32;
	localparam int TotalW        = 64;
	localparam int IndexW        = 6;
	localparam logic [TickW-1:0] CountLimit = 32'hffff_ffff;

	typedef enum logic [1:0] {
		ST_UPDATED = 2'd0,
		ST_NEW     = 2'd1,
		ST_FULL    = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_STAT_RD,
		S_STAT_WB,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [TickW-1:0] proc_id;
		logic [TickW-1:0] entry_tick;
		logic [TickW-1:0] exit_tick;
	} in_item_t;

	typedef struct packed {
		status_t           status;
		logic [IndexW-1:0] entry_index;
		logic [TickW-1:0]  min_ticks;
		logic [TickW-1:0]  max_ticks;
		logic [TotalW-1:0] total_ticks;
		logic [TickW-1:0]  call_count;
	} out_item_t;

	typedef struct packed {
		logic [TickW-1:0]  min_ticks;
		logic [TickW-1:0]  max_ticks;
		logic [TotalW-1:0] total_ticks;
		logic [TickW-1:0]  call_count;
	} stat_t;

endpackage

### rtl/cdst_ram.sv
// simple dual-port synchronous memory, one write and one registered read port
// no dependencies
module cdst_ram #(
	parameter int Width = 32,
	parameter int Depth = 64,
	localparam int AW = $clog2(Depth)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [Width-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/cdst_ctrl.sv
// scan, update and fill sequencer with the identifier and statistics memories
// depends on cdst_pkg, cdst_ram and call_duration_stats_table_macros.svh
`include "call_duration_stats_table_macros.svh"

module cdst_ctrl #(
	parameter int TABLE_SLOTS = cdst_pkg::TableSlotsDef,
	localparam int AW = $clog2(TABLE_SLOTS),
	localparam int UW = $clog2(TABLE_SLOTS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                stats_enable,
	input  logic                in_valid,
	output logic                in_ready,
	input  cdst_pkg::in_item_t  in_item,
	output logic                res_valid,
	input  logic                res_ready,
	output cdst_pkg::out_item_t res_item
);

	localparam int StatW = $bits(cdst_pkg::stat_t);

	cdst_pkg::state_t state_q, state_d;

	logic [cdst_pkg::TickW-1:0] id_q;
	logic [cdst_pkg::TickW-1:0] elapsed_q;
	logic [UW-1:0]              used_q;
	logic [UW-1:0]              rd_addr_q;
	logic                       cmp_valid_q;
	logic [AW-1:0]              cmp_addr_q;
	logic [AW-1:0]              hit_idx_q;
	cdst_pkg::out_item_t        res_q;

	logic                       accept;
	logic                       ignore;
	logic                       issue;
	logic                       hit;
	logic                       miss;
	logic                       full;
	logic                       id_we;
	logic                       stat_we;
	logic [AW-1:0]              stat_waddr;
	logic [cdst_pkg::TickW-1:0] id_rdata;
	logic [StatW-1:0]           stat_rdata;
	cdst_pkg::stat_t            stat_old;
	cdst_pkg::stat_t            stat_new;
	cdst_pkg::stat_t            stat_upd;
	cdst_pkg::stat_t            stat_wdata;

	cdst_ram #(
		.Width(cdst_pkg::TickW),
		.Depth(TABLE_SLOTS)
	) u_id_ram (
		.clk  (clk),
		.we   (id_we),
		.waddr(used_q[AW-1:0]),
		.wdata(id_q),
		.raddr(rd_addr_q[AW-1:0]),
		.rdata(id_rdata)
	);

	cdst_ram #(
		.Width(StatW),
		.Depth(TABLE_SLOTS)
	) u_stat_ram (
		.clk  (clk),
		.we   (stat_we),
		.waddr(stat_waddr),
		.wdata(stat_wdata),
		.raddr(hit_idx_q),
		.rdata(stat_rdata)
	);

	assign accept = in_valid && in_ready;
	assign ignore = !stats_enable || (in_item.proc_id == '0);
	assign issue  = rd_addr_q < used_q;
	assign hit    = cmp_valid_q && (id_rdata == id_q);
	assign miss   = !issue && !cmp_valid_q;
	assign full   = used_q == UW'(TABLE_SLOTS);

	// read-modify-write of one statistics entry, and the initial entry for a new identifier
	always_comb begin
		stat_old = cdst_pkg::stat_t'(stat_rdata);
		stat_upd = stat_old;
		if (elapsed_q < stat_old.min_ticks) begin
			stat_upd.min_ticks = elapsed_q;
		end
		if (elapsed_q > stat_old.max_ticks) begin
			stat_upd.max_ticks = elapsed_q;
		end
		if (stat_old.call_count != cdst_pkg::CountLimit) begin
			stat_upd.total_ticks = stat_old.total_ticks
				+ cdst_pkg::TotalW'(elapsed_q);
			stat_upd.call_count = stat_old.call_count + 1'b1;
		end
		stat_new.min_ticks   = elapsed_q;
		stat_new.max_ticks   = elapsed_q;
		stat_new.total_ticks = cdst_pkg::TotalW'(elapsed_q);
		stat_new.call_count  = cdst_pkg::TickW'(1);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cdst_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = ignore ? cdst_pkg::S_DONE : cdst_pkg::S_SCAN;
				end
			end
			cdst_pkg::S_SCAN: begin
				if (hit) begin
					state_d = cdst_pkg::S_STAT_RD;
				end else if (miss) begin
					state_d = cdst_pkg::S_DONE;
				end
			end
			cdst_pkg::S_STAT_RD: state_d = cdst_pkg::S_STAT_WB;
			cdst_pkg::S_STAT_WB: state_d = cdst_pkg::S_DONE;
			cdst_pkg::S_DONE: begin
				if (res_ready) begin
					state_d = cdst_pkg::S_IDLE;
				end
			end
			default: state_d = cdst_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = state_q == cdst_pkg::S_IDLE;
		res_valid  = state_q == cdst_pkg::S_DONE;
		id_we      = (state_q == cdst_pkg::S_SCAN) && !hit && miss && !full;
		stat_we    = id_we || (state_q == cdst_pkg::S_STAT_WB);
		stat_waddr = id_we ? used_q[AW-1:0] : hit_idx_q;
		stat_wdata = id_we ? stat_new : stat_upd;
	end

	assign res_item = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cdst_pkg::S_IDLE;
			used_q      <= '0;
			rd_addr_q   <= '0;
			cmp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (id_we) begin
				used_q <= used_q + 1'b1;
			end
			if (state_q == cdst_pkg::S_SCAN) begin
				cmp_valid_q <= issue && !hit;
				if (issue) begin
					rd_addr_q <= rd_addr_q + 1'b1;
				end
			end else begin
				rd_addr_q   <= '0;
				cmp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q      <= in_item.proc_id;
			elapsed_q <= in_item.exit_tick - in_item.entry_tick;
			if (ignore) begin
				res_q <= '{status: cdst_pkg::ST_IGNORED, entry_index: '0, min_ticks: '0,
					max_ticks: '0, total_ticks: '0, call_count: '0};
			end
		end
		if (state_q == cdst_pkg::S_SCAN) begin
			cmp_addr_q <= rd_addr_q[AW-1:0];
			if (hit) begin
				hit_idx_q <= cmp_addr_q;
			end else if (miss) begin
				if (full) begin
					res_q <= '{status: cdst_pkg::ST_FULL, entry_index: '0, min_ticks: '0,
						max_ticks: '0, total_ticks: '0, call_count: '0};
				end else begin
					res_q.status      <= cdst_pkg::ST_NEW;
					res_q.entry_index <= cdst_pkg::IndexW'(used_q[AW-1:0]);
					res_q.min_ticks   <= stat_new.min_ticks;
					res_q.max_ticks   <= stat_new.max_ticks;
					res_q.total_ticks <= stat_new.total_ticks;
					res_q.call_count  <= stat_new.call_count;
				end
			end
		end
		if (state_q == cdst_pkg::S_STAT_WB) begin
			res_q.status      <= cdst_pkg::ST_UPDATED;
			res_q.entry_index <= cdst_pkg::IndexW'(hit_idx_q);
			res_q.min_ticks   <= stat_upd.min_ticks;
			res_q.max_ticks   <= stat_upd.max_ticks;
			res_q.total_ticks <= stat_upd.total_ticks;
			res_q.call_count  <= stat_upd.call_count;
		end
	end

	`CDST_ASSERT_ALWAYS(a_used_bound, used_q <= UW'(TABLE_SLOTS), "used count beyond table size")
	`CDST_ASSERT(a_fill_step, id_we |=> used_q == $past(used_q) + 1'b1, "fill did not advance count")
	`CDST_ASSERT(a_scan_bound, state_q == cdst_pkg::S_SCAN |-> rd_addr_q <= used_q, "scan past used slots")
	`CDST_ASSERT(a_wb_after_rd, state_q == cdst_pkg::S_STAT_WB |-> $past(state_q) == cdst_pkg::S_STAT_RD, "write-back without read")

endmodule

### rtl/call_duration_stats_table.sv
// top level of the call duration statistics table: config register and result register
// depends on cdst_pkg and cdst_ctrl
//
//  channel  | handshake            | payload
//  input    | in_valid / in_ready  | in_item  (cdst_pkg::in_item_t)
//  output   | out_valid / out_ready| out_item (cdst_pkg::out_item_t)
//  config   | cfg_we               | cfg_wdata (stats_enable)
//
// an item is matched by the one-slot-per-cycle scan of the identifier memory over the used slots,
// at most TABLE_SLOTS of them
// ignored items skip the scan; a hit adds a read and a write-back of the statistics memory
// reset clears the used count, scan pointer, state, enable and output valid; memories need no clearing pass
// one result register decouples the output; a new item is taken while it waits
module call_duration_stats_table #(
	parameter int TABLE_SLOTS = cdst_pkg::TableSlotsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  cdst_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output cdst_pkg::out_item_t out_item
);

	logic                stats_enable_q;
	logic                out_valid_q;
	cdst_pkg::out_item_t out_item_q;
	logic                res_valid;
	logic                res_ready;
	cdst_pkg::out_item_t res_item;

	cdst_ctrl #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.stats_enable(stats_enable_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res_item    (res_item)
	);

	assign res_ready = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stats_enable_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				stats_enable_q <= cfg_wdata;
			end
			if (res_ready) begin
				out_valid_q <= res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_item_q <= res_item;
		end
	end

endmodule
